>>> design/sorted_unique_set_store_core_macros.svh
// Assertion macros for the sorted unique set store.
// Used by the checker module; the checker must declare clk and rst.
`ifndef SORTED_UNIQUE_SET_STORE_CORE_MACROS_SVH
`define SORTED_UNIQUE_SET_STORE_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SUS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define SUS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/sus_pkg.sv
// Shared types and constants for the sorted unique set store.
// No dependencies; every design module imports this package.
package sus_pkg;

  localparam int DEPTH       = 9;
  localparam int VALUE_WIDTH = 32;
  localparam int IN_VALUE_W  = 32;
  localparam int COUNT_W     = 4;
  localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W       = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_REPLY
  } seq_state_t;

  typedef logic signed [VALUE_WIDTH-1:0] entry_t;

  typedef struct packed {
    cmd_t                          cmd;
    logic signed [IN_VALUE_W-1:0]  value;
  } req_t;

  typedef struct packed {
    logic               ok;
    logic [COUNT_W-1:0] count;
  } rsp_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
  } store_ctl_t;

  typedef struct packed {
    logic eq;
    logic lt;
  } cmp_res_t;

endpackage

>>> design/sorted_unique_set_store_core.sv
// Sorted set of up to DEPTH distinct nonzero signed values, kept in ascending
// order in one register bank; insert, remove and lookup each return one item
// with a success flag and the count. One command is in work at a time: req_ready
// is high only when the sequencer is idle. A command walks the entries through
// one shared compare unit, one entry per cycle, and an insert or remove then
// moves one entry per cycle through the single write port, starting at the
// slot pos at which the walk stopped: an insert up to slot count, a remove
// always up through the top slot. The reply step loads the result register and
// the idle step takes the next item; a no-op goes straight from idle to reply.
// A result that is still waiting holds the sequencer in its last step until it
// is taken, but the result register lets the next command start while one
// result waits.
module sorted_unique_set_store_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  sus_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output sus_pkg::rsp_t rsp
);
  import sus_pkg::*;

  store_ctl_t ctl;
  entry_t     rdata;
  entry_t     operand;
  cmp_res_t   cmp;

  sus_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .ctl       (ctl),
    .rdata     (rdata),
    .operand   (operand),
    .cmp       (cmp)
  );

  sus_store u_store (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .rdata (rdata)
  );

  sus_cmp u_cmp (
    .entry   (rdata),
    .operand (operand),
    .res     (cmp)
  );

endmodule

>>> design/sus_cmp.sv
// Shared compare unit: equality and signed less-than of a stored entry
// against the operand. Depends on sus_pkg.
module sus_cmp (
  input  sus_pkg::entry_t   entry,
  input  sus_pkg::entry_t   operand,
  output sus_pkg::cmp_res_t res
);
  import sus_pkg::*;

  assign res.eq = (entry == operand);
  assign res.lt = (entry < operand);

endmodule

>>> design/sus_store.sv
// Entry registers of the set, one write port and one read port.
// Reset empties every slot. Depends on sus_pkg.
module sus_store (
  input  logic                clk,
  input  logic                rst,
  input  sus_pkg::store_ctl_t ctl,
  output sus_pkg::entry_t     rdata
);
  import sus_pkg::*;

  entry_t slots [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DEPTH; k++) begin
        slots[k] <= '0;
      end
    end else if (ctl.we) begin
      slots[ctl.waddr] <= ctl.wdata;
    end
  end

  assign rdata = (int'(ctl.raddr) < DEPTH) ? slots[ctl.raddr] : '0;

endmodule

>>> design/sus_seq.sv
// Command sequencer: scans the entries through the shared compare unit,
// then for an insert or remove shifts them by one slot, one per cycle. Depends on sus_pkg.
module sus_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  sus_pkg::req_t       req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output sus_pkg::rsp_t       rsp,
  output sus_pkg::store_ctl_t ctl,
  input  sus_pkg::entry_t     rdata,
  output sus_pkg::entry_t     operand,
  input  sus_pkg::cmp_res_t   cmp
);
  import sus_pkg::*;

  seq_state_t       state, state_next;
  cmd_t             op, op_next;
  entry_t           operand_next;
  entry_t           carry, carry_next;
  logic [CNT_W-1:0] idx, idx_next;
  logic [CNT_W-1:0] occupied, occupied_next;
  logic             ok, ok_next;
  logic             rsp_valid_next;
  rsp_t             rsp_next;
  logic             at_end;
  logic             full;
  logic             top_slot;

  assign at_end   = (idx == occupied);
  assign full     = (occupied == CNT_W'(DEPTH));
  assign top_slot = (idx == CNT_W'(DEPTH - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      occupied  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      occupied  <= occupied_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    op      <= op_next;
    operand <= operand_next;
    carry   <= carry_next;
    idx     <= idx_next;
    ok      <= ok_next;
    rsp     <= rsp_next;
  end

  always_comb begin
    state_next     = state;
    op_next        = op;
    operand_next   = operand;
    carry_next     = carry;
    idx_next       = idx;
    occupied_next  = occupied;
    ok_next        = ok;
    rsp_next       = rsp;
    rsp_valid_next = rsp_valid && !rsp_ready;
    req_ready      = 1'b0;
    ctl.we         = 1'b0;
    ctl.waddr      = idx[IDX_W-1:0];
    ctl.wdata      = carry;
    ctl.raddr      = idx[IDX_W-1:0];

    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          op_next      = req.cmd;
          operand_next = VALUE_WIDTH'(req.value);
          idx_next     = '0;
          ok_next      = 1'b0;
          state_next   = (req.cmd == CMD_NOP) ? ST_REPLY : ST_SCAN;
        end
      end

      ST_SCAN: begin
        // The scan stops at the first entry not below the operand, which is
        // both the match position and the insertion point.
        if (at_end || cmp.eq || !cmp.lt) begin
          unique case (op)
            CMD_INSERT: begin
              if (operand != '0 && !full && !(!at_end && cmp.eq)) begin
                carry_next = operand;
                state_next = ST_SHIFT;
              end else begin
                state_next = ST_REPLY;
              end
            end
            CMD_REMOVE: begin
              state_next = (!at_end && cmp.eq) ? ST_SHIFT : ST_REPLY;
            end
            CMD_LOOKUP: begin
              ok_next    = !at_end && cmp.eq;
              state_next = ST_REPLY;
            end
            default: begin
              state_next = ST_REPLY;
            end
          endcase
        end else begin
          idx_next = idx + 1'b1;
        end
      end

      ST_SHIFT: begin
        ctl.we = 1'b1;
        if (op == CMD_INSERT) begin
          // Ripple the carried value up: each slot takes the one below it.
          carry_next = rdata;
          if (at_end) begin
            occupied_next = occupied + 1'b1;
            ok_next       = 1'b1;
            state_next    = ST_REPLY;
          end else begin
            idx_next = idx + 1'b1;
          end
        end else begin
          if (top_slot) begin
            ctl.wdata     = '0;
            occupied_next = occupied - 1'b1;
            ok_next       = 1'b1;
            state_next    = ST_REPLY;
          end else begin
            ctl.raddr = IDX_W'(idx + 1'b1);
            ctl.wdata = rdata;
            idx_next  = idx + 1'b1;
          end
        end
      end

      ST_REPLY: begin
        if (!rsp_valid || rsp_ready) begin
          rsp_next.ok    = ok;
          rsp_next.count = COUNT_W'(occupied);
          rsp_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> design/sus_checker.sv
// Port-level checks for the sorted unique set store, bound to the top level.
// Depends on sus_pkg and sorted_unique_set_store_core_macros.svh.
`include "sorted_unique_set_store_core_macros.svh"

module sus_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input sus_pkg::rsp_t rsp
);
  import sus_pkg::*;

  logic [COUNT_W-1:0] last_count;
  logic               count_near;

  // Count reported by the last delivered item.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_count <= '0;
    end else if (rsp_valid && rsp_ready) begin
      last_count <= rsp.count;
    end
  end

  assign count_near = (rsp.count == last_count) ||
                      (rsp.count == last_count + 1'b1) ||
                      (rsp.count == last_count - 1'b1);

  `SUS_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "ready after accept")
  `SUS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "result dropped")
  `SUS_ASSERT_NOW(a_fail_keeps_count, rsp_valid && !rsp.ok, rsp.count == last_count, "count moved")
  `SUS_ASSERT_NOW(a_count_step, rsp_valid && rsp.ok, count_near, "count jumped")

endmodule

bind sorted_unique_set_store_core sus_checker u_sus_checker (.*);
